// ===== rtl/tsm_pkg.sv =====
// Shared types and constants for the two-way sorted merge.
// Used by the front end, the back end, the top level and the bench; no dependencies of its own.
package tsm_pkg;

  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned CMD_FIFO_DEPTH = 2;
  localparam int unsigned RES_FIFO_DEPTH = 2;

  localparam logic LIST_A = 1'b0;
  localparam logic LIST_B = 1'b1;

  typedef enum logic [1:0] {
    ST_ELEM      = 2'd0,
    ST_DROP_FULL = 2'd1,
    ST_DONE      = 2'd2,
    ST_DROP_END  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_MERGE
  } back_state_t;

  // One classified input item as passed from front to back.
  typedef struct packed {
    logic                       which_list;
    logic                       has_value;
    logic signed [VALUE_W-1:0]  value;
    logic                       ends_list;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic signed [VALUE_W-1:0]  merged_value;
    logic                       from_list;
    logic                       last;
    status_t                    status;
  } res_t;

endpackage

// ===== rtl/tsm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tsm_fifo.sv =====
// Small register FIFO used for the command and result queues.
// No dependencies.
module tsm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PW-1:0]    wr_r, wr_nxt;
  logic [PW-1:0]    rd_r, rd_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/tsm_front.sv =====
// Front end of the merge: accepts input items, drops items that carry
// neither an element nor an end mark, and queues the rest for the back end.
// Depends on tsm_pkg and tsm_fifo.
module tsm_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  tsm_pkg::cmd_t in_cmd,
  output logic          cmd_valid,
  input  logic          cmd_pop,
  output tsm_pkg::cmd_t cmd_data
);

  logic q_full, q_empty, q_push;

  // an item with no element and no end mark changes nothing: drop it here
  assign q_push    = in_push && !q_full && (in_cmd.has_value || in_cmd.ends_list);
  assign in_full   = q_full;
  assign cmd_valid = !q_empty;

  tsm_fifo #(
    .WIDTH ($bits(tsm_pkg::cmd_t)),
    .DEPTH (tsm_pkg::CMD_FIFO_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (in_cmd),
    .full  (q_full),
    .pop   (cmd_pop),
    .rdata (cmd_data),
    .empty (q_empty)
  );

endmodule

// ===== rtl/tsm_back.sv =====
// Back end of the merge: per-list head queues in RAM, end flags, merge
// sequencer and the result queue.
// Depends on tsm_pkg, tsm_ram and tsm_fifo.
module tsm_back #(
  parameter int unsigned DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_pop,
  input  tsm_pkg::cmd_t cmd_data,
  output logic          res_empty,
  input  logic          res_pop,
  output tsm_pkg::res_t res_data
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  tsm_pkg::back_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [AW-1:0] rd_a_r, rd_a_nxt, rd_b_r, rd_b_nxt;
  logic [AW-1:0] wr_a_r, wr_a_nxt, wr_b_r, wr_b_nxt;
  logic          ended_a_r, ended_a_nxt, ended_b_r, ended_b_nxt;
  logic          elems_r, elems_nxt;

  logic                              we_a, we_b;
  logic [tsm_pkg::VALUE_W-1:0]       head_a_raw, head_b_raw;
  logic signed [tsm_pkg::VALUE_W-1:0] head_a, head_b;
  logic          b_less, take_a, take_b;
  logic          res_push, res_full;
  tsm_pkg::res_t res_in;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head_a = $signed(head_a_raw);
  assign head_b = $signed(head_b_raw);
  assign b_less = head_b < head_a;
  // smaller head first, A wins a tie; a lone list drains once the other ended
  assign take_a = (cnt_a_r != '0) && (((cnt_b_r != '0) && !b_less) ||
                                     ((cnt_b_r == '0) && ended_b_r));
  assign take_b = (cnt_b_r != '0) && (((cnt_a_r != '0) && b_less) ||
                                     ((cnt_a_r == '0) && ended_a_r));

  always_comb begin
    state_nxt   = state_r;
    cnt_a_nxt   = cnt_a_r;
    cnt_b_nxt   = cnt_b_r;
    rd_a_nxt    = rd_a_r;
    rd_b_nxt    = rd_b_r;
    wr_a_nxt    = wr_a_r;
    wr_b_nxt    = wr_b_r;
    ended_a_nxt = ended_a_r;
    ended_b_nxt = ended_b_r;
    elems_nxt   = elems_r;
    we_a        = 1'b0;
    we_b        = 1'b0;
    cmd_pop     = 1'b0;
    res_push    = 1'b0;
    res_in      = '{merged_value: '0, from_list: 1'b0, last: 1'b0,
                    status: tsm_pkg::ST_ELEM};
    case (state_r)
      tsm_pkg::S_IDLE: begin
        if (cmd_valid && !res_full) begin
          cmd_pop   = 1'b1;
          elems_nxt = 1'b0;
          state_nxt = tsm_pkg::S_MERGE;
          res_in.from_list = cmd_data.which_list;
          if (cmd_data.which_list == tsm_pkg::LIST_A) begin
            if (ended_a_r) begin
              res_push            = 1'b1;
              res_in.merged_value = cmd_data.has_value ? cmd_data.value : '0;
              res_in.status       = tsm_pkg::ST_DROP_END;
            end else begin
              if (cmd_data.has_value) begin
                if (cnt_a_r >= CW'(DEPTH)) begin
                  res_push            = 1'b1;
                  res_in.merged_value = cmd_data.value;
                  res_in.status       = tsm_pkg::ST_DROP_FULL;
                end else begin
                  we_a      = 1'b1;
                  wr_a_nxt  = ptr_inc(wr_a_r);
                  cnt_a_nxt = cnt_a_r + 1'b1;
                  if (cnt_a_r == '0) begin
                    state_nxt = tsm_pkg::S_WAIT;
                  end
                end
              end
              if (cmd_data.ends_list) begin
                ended_a_nxt = 1'b1;
              end
            end
          end else begin
            if (ended_b_r) begin
              res_push            = 1'b1;
              res_in.merged_value = cmd_data.has_value ? cmd_data.value : '0;
              res_in.status       = tsm_pkg::ST_DROP_END;
            end else begin
              if (cmd_data.has_value) begin
                if (cnt_b_r >= CW'(DEPTH)) begin
                  res_push            = 1'b1;
                  res_in.merged_value = cmd_data.value;
                  res_in.status       = tsm_pkg::ST_DROP_FULL;
                end else begin
                  we_b      = 1'b1;
                  wr_b_nxt  = ptr_inc(wr_b_r);
                  cnt_b_nxt = cnt_b_r + 1'b1;
                  if (cnt_b_r == '0) begin
                    state_nxt = tsm_pkg::S_WAIT;
                  end
                end
              end
              if (cmd_data.ends_list) begin
                ended_b_nxt = 1'b1;
              end
            end
          end
        end
      end
      tsm_pkg::S_WAIT: begin
        // new head written into an empty queue: let the RAM read catch up
        state_nxt = tsm_pkg::S_MERGE;
      end
      tsm_pkg::S_MERGE: begin
        if (take_a || take_b) begin
          if (!res_full) begin
            res_push            = 1'b1;
            elems_nxt           = 1'b1;
            res_in.merged_value = take_b ? head_b : head_a;
            res_in.from_list    = take_b;
            if (take_b) begin
              rd_b_nxt    = ptr_inc(rd_b_r);
              cnt_b_nxt   = cnt_b_r - 1'b1;
              res_in.last = ended_a_r && ended_b_r && (cnt_b_r == CW'(1)) &&
                            (cnt_a_r == '0);
            end else begin
              rd_a_nxt    = ptr_inc(rd_a_r);
              cnt_a_nxt   = cnt_a_r - 1'b1;
              res_in.last = ended_a_r && ended_b_r && (cnt_a_r == CW'(1)) &&
                            (cnt_b_r == '0);
            end
          end
        end else if (ended_a_r && ended_b_r) begin
          if (elems_r || !res_full) begin
            if (!elems_r) begin
              res_push      = 1'b1;
              res_in.last   = 1'b1;
              res_in.status = tsm_pkg::ST_DONE;
            end
            cnt_a_nxt   = '0;
            cnt_b_nxt   = '0;
            ended_a_nxt = 1'b0;
            ended_b_nxt = 1'b0;
            state_nxt   = tsm_pkg::S_IDLE;
          end
        end else begin
          state_nxt = tsm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tsm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tsm_pkg::S_IDLE;
      cnt_a_r   <= '0;
      cnt_b_r   <= '0;
      rd_a_r    <= '0;
      rd_b_r    <= '0;
      wr_a_r    <= '0;
      wr_b_r    <= '0;
      ended_a_r <= 1'b0;
      ended_b_r <= 1'b0;
      elems_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_a_r   <= cnt_a_nxt;
      cnt_b_r   <= cnt_b_nxt;
      rd_a_r    <= rd_a_nxt;
      rd_b_r    <= rd_b_nxt;
      wr_a_r    <= wr_a_nxt;
      wr_b_r    <= wr_b_nxt;
      ended_a_r <= ended_a_nxt;
      ended_b_r <= ended_b_nxt;
      elems_r   <= elems_nxt;
    end
  end

  // read address follows the next head pointer so the head is current
  // from the cycle after every pop
  tsm_ram #(.WIDTH(tsm_pkg::VALUE_W), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (wr_a_r),
    .wdata (cmd_data.value),
    .raddr (rd_a_nxt),
    .rdata (head_a_raw)
  );

  tsm_ram #(.WIDTH(tsm_pkg::VALUE_W), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (wr_b_r),
    .wdata (cmd_data.value),
    .raddr (rd_b_nxt),
    .rdata (head_b_raw)
  );

  tsm_fifo #(
    .WIDTH ($bits(tsm_pkg::res_t)),
    .DEPTH (tsm_pkg::RES_FIFO_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (res_pop),
    .rdata (res_data),
    .empty (res_empty)
  );

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_a_r <= CW'(DEPTH)) && (cnt_b_r <= CW'(DEPTH)))
    else $error("queue count beyond depth");

  a_idle_not_both_ended: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsm_pkg::S_IDLE) |-> !(ended_a_r && ended_b_r))
    else $error("both lists ended while idle");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  a_take_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsm_pkg::S_MERGE) |-> !(take_a && take_b))
    else $error("both heads selected");

  a_wait_follows_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsm_pkg::S_WAIT) |-> $past(we_a || we_b))
    else $error("wait state without a head write");

endmodule

// ===== rtl/two_way_sorted_merge.sv =====
// Top level of the two-way merge of sorted sequences.
// Depends on tsm_pkg, tsm_front and tsm_back (and through them tsm_fifo, tsm_ram).
//
// Merges two ascending lists, A and B, whose elements arrive interleaved,
// each tagged with its list and optionally closing it; a bare end marker
// closes an empty list. Both sides look like queues: transfer in with push
// while full is low, transfer out with pop while empty is low. After each
// item the block emits every element it can already place: smaller head
// first, A first on a tie, and once one list has ended the other drains.
// The final element of a merge carries last; if both lists end with no
// element left to give, one done result (status 2, last set) is given
// instead. An element pushed into a full list queue is dropped with status 1
// (an end mark on the same item still counts); any item for a list that has
// already ended is dropped with status 3. After both lists end everything
// clears for the next pair. Items with neither an element nor an end mark
// are absorbed silently. Flow: an item waits in the front queue until the
// sequencer is idle with room in the result queue, and is applied when
// popped (a drop result is queued in that cycle); an element landing in an
// empty list queue adds a wait state (head RAM read latency); then each
// element that can be placed is emitted, stalling while the result queue is
// full, and a closing merge step follows. One merge sequencer owns both head
// RAMs and takes a new item only from idle. Results wait in a small output
// queue; with the consumer stalled, back end and front queue run until full.
module two_way_sorted_merge #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_which_list,
  input  logic        in_has_value,
  input  logic signed [31:0] in_value,
  input  logic        in_ends_list,
  output logic        out_empty,
  input  logic        out_pop,
  output logic signed [31:0] out_merged_value,
  output logic        out_from_list,
  output logic        out_last,
  output logic [1:0]  out_status
);

  tsm_pkg::cmd_t in_cmd, cmd_data;
  tsm_pkg::res_t res_data;
  logic          cmd_valid, cmd_pop;

  // pack the input transfer into a command
  assign in_cmd.which_list = in_which_list;
  assign in_cmd.has_value  = in_has_value;
  assign in_cmd.value      = in_value;
  assign in_cmd.ends_list  = in_ends_list;

  tsm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_cmd    (in_cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_data  (cmd_data)
  );

  tsm_back #(.DEPTH(QUEUE_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_data  (cmd_data),
    .res_empty (out_empty),
    .res_pop   (out_pop),
    .res_data  (res_data)
  );

  // unpack the oldest waiting result onto the result ports
  assign out_merged_value = res_data.merged_value;
  assign out_from_list    = res_data.from_list;
  assign out_last         = res_data.last;
  assign out_status       = res_data.status;

endmodule

// ===== sim/testbench.sv =====
// Self-checking bench for two_way_sorted_merge: interleaved sorted lists go in,
// each merged result is checked against a behavioural predictor held here.
// Depends on tsm_pkg and the RTL of the block only.
module testbench;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned ITEM_TARGET = 210;
  localparam int          SHOW_MAX    = 10;
  // Allow several times the worst correct run.
  localparam longint      LIMIT_TIME  = 64'd12_000_000;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  logic               in_which_list;
  logic               in_has_value;
  logic signed [31:0] in_value;
  logic               in_ends_list;
  logic               out_empty;
  logic               out_pop;
  logic signed [31:0] out_merged_value;
  logic               out_from_list;
  logic               out_last;
  logic [1:0]         out_status;

  // Predictor state: waiting heads of each list and their end flags.
  logic signed [31:0] held_a[$];
  logic signed [31:0] held_b[$];
  bit                 closed_a;
  bit                 closed_b;
  tsm_pkg::res_t      merged_expect[$];

  // Run statistics.
  int items_sent;
  int results_seen;
  int drop_count;
  int merge_count;
  int fault_count;

  // When set, neither side idles nor stalls.
  bit steady;

  two_way_sorted_merge #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_which_list    (in_which_list),
    .in_has_value     (in_has_value),
    .in_value         (in_value),
    .in_ends_list     (in_ends_list),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_merged_value (out_merged_value),
    .out_from_list    (out_from_list),
    .out_last         (out_last),
    .out_status       (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop: a run that hangs ends here as a failure.
  initial begin
    #(LIMIT_TIME);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic tsm_pkg::res_t make_res(logic signed [31:0] v, logic from,
                                             logic closing, tsm_pkg::status_t st);
    tsm_pkg::res_t r;
    r.merged_value = v;
    r.from_list    = from;
    r.last         = closing;
    r.status       = st;
    return r;
  endfunction

  // Apply one accepted item to the predictor and queue every result it causes.
  function automatic void predict_merge(logic which, logic has, logic signed [31:0] val,
                                        logic ends);
    int                 emitted;
    logic               pick;
    logic signed [31:0] head;
    bit                 own_closed;
    bit                 closing;
    emitted    = 0;
    own_closed = (which == tsm_pkg::LIST_B) ? closed_b : closed_a;
    if (own_closed) begin
      // Anything aimed at an ended list is dropped whole, bare end marks too.
      if (has || ends) begin
        merged_expect.push_back(make_res(has ? val : 32'sd0, which, 1'b0,
                                         tsm_pkg::ST_DROP_END));
        drop_count++;
      end
    end else begin
      if (has) begin
        if (((which == tsm_pkg::LIST_B) ? held_b.size() : held_a.size()) >= DEPTH) begin
          // Full list queue: drop the element, but let an end mark still count.
          merged_expect.push_back(make_res(val, which, 1'b0, tsm_pkg::ST_DROP_FULL));
          drop_count++;
        end else if (which == tsm_pkg::LIST_B) begin
          held_b.push_back(val);
        end else begin
          held_a.push_back(val);
        end
      end
      if (ends) begin
        if (which == tsm_pkg::LIST_B) closed_b = 1'b1;
        else closed_a = 1'b1;
      end
    end
    // Emit every element whose place is already decided; ties favour A.
    while (1) begin
      if (held_a.size() > 0 && held_b.size() > 0) begin
        pick = (held_b[0] < held_a[0]) ? tsm_pkg::LIST_B : tsm_pkg::LIST_A;
      end else if (held_a.size() > 0 && closed_b) begin
        pick = tsm_pkg::LIST_A;
      end else if (held_b.size() > 0 && closed_a) begin
        pick = tsm_pkg::LIST_B;
      end else begin
        break;
      end
      head    = (pick == tsm_pkg::LIST_B) ? held_b.pop_front() : held_a.pop_front();
      closing = closed_a && closed_b && held_a.size() == 0 && held_b.size() == 0;
      merged_expect.push_back(make_res(head, pick, closing, tsm_pkg::ST_ELEM));
      emitted++;
    end
    // Both lists closed: flag completion if nothing went out, then clear.
    if (closed_a && closed_b) begin
      if (emitted == 0)
        merged_expect.push_back(make_res(32'sd0, tsm_pkg::LIST_A, 1'b1, tsm_pkg::ST_DONE));
      held_a.delete();
      held_b.delete();
      closed_a = 1'b0;
      closed_b = 1'b0;
      merge_count++;
    end
  endfunction

  // Sender idling: mostly none, sometimes short, rarely long.
  task automatic idle_gap();
    int roll;
    int n;
    roll = $urandom_range(0, 99);
    if (steady || roll < 70) n = 0;
    else if (roll < 95) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n > 0) begin
      @(negedge clk);
      in_push = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Offer one item, hold it until the transfer happens, then predict it.
  task automatic send_item(logic which, logic has, logic signed [31:0] val, logic ends);
    @(negedge clk);
    in_push       = 1'b1;
    in_which_list = which;
    in_has_value  = has;
    in_value      = val;
    in_ends_list  = ends;
    do @(posedge clk); while (in_full);
    predict_merge(which, has, val, ends);
    if (has || ends) items_sent++;
    idle_gap();
  endtask

  // Hold the sender off until every expected result has been taken.
  task automatic wait_drained();
    @(negedge clk);
    in_push = 1'b0;
    while (merged_expect.size() != 0) @(posedge clk);
  endtask

  // Result side: stall at random, take each transfer at the rising edge and
  // compare it field by field with the oldest expectation.
  initial begin : result_check
    tsm_pkg::res_t got;
    tsm_pkg::res_t want;
    int            stall_left;
    int            roll;
    out_pop    = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_pop = 1'b0;
        stall_left--;
      end else begin
        out_pop = 1'b1;
        roll    = $urandom_range(0, 99);
        if (!steady && roll < 5) stall_left = $urandom_range(8, 40);
        else if (!steady && roll < 25) stall_left = $urandom_range(1, 3);
      end
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        got = make_res(out_merged_value, out_from_list, out_last,
                       tsm_pkg::status_t'(out_status));
        results_seen++;
        if (merged_expect.size() == 0) begin
          fault_count++;
          if (fault_count <= SHOW_MAX)
            $display("%0t: unexpected result value %0d list %0d last %0d status %s",
                     $realtime, got.merged_value, got.from_list, got.last, got.status.name());
        end else begin
          want = merged_expect.pop_front();
          if (got.merged_value !== want.merged_value || got.from_list !== want.from_list ||
              got.last !== want.last || got.status !== want.status) begin
            fault_count++;
            if (fault_count <= SHOW_MAX)
              $display("%0t: wrong result: want %0d/%0d/%0d/%s got %0d/%0d/%0d/%s",
                       $realtime, want.merged_value, want.from_list, want.last,
                       want.status.name(), got.merged_value, got.from_list, got.last,
                       got.status.name());
          end
        end
      end
    end
  end

  // Empty item, then two bare end marks: one done result.
  task automatic test_empty_lists();
    send_item(tsm_pkg::LIST_A, 1'b0, 32'sd77, 1'b0);
    send_item(tsm_pkg::LIST_A, 1'b0, 32'sd0, 1'b1);
    send_item(tsm_pkg::LIST_B, 1'b0, 32'sd0, 1'b1);
  endtask

  // Range extremes, ties and a bare end mark that releases the other list.
  task automatic test_extremes_and_ties();
    send_item(tsm_pkg::LIST_A, 1'b1, 32'sh8000_0000, 1'b0);
    send_item(tsm_pkg::LIST_B, 1'b1, 32'sh8000_0000, 1'b1);
    send_item(tsm_pkg::LIST_A, 1'b1, 32'sh7fff_ffff, 1'b1);
    send_item(tsm_pkg::LIST_A, 1'b1, 32'sd7, 1'b0);
    send_item(tsm_pkg::LIST_B, 1'b1, -32'sd1, 1'b0);
    send_item(tsm_pkg::LIST_B, 1'b1, 32'sd7, 1'b1);
    send_item(tsm_pkg::LIST_A, 1'b0, 32'sd0, 1'b1);
  endtask

  // Items for a list that has already ended, on either side.
  task automatic test_drop_after_end();
    send_item(tsm_pkg::LIST_A, 1'b1, 32'sd9, 1'b1);
    send_item(tsm_pkg::LIST_A, 1'b1, 32'sd11, 1'b0);
    send_item(tsm_pkg::LIST_A, 1'b0, 32'sd0, 1'b1);
    send_item(tsm_pkg::LIST_A, 1'b0, 32'sd5, 1'b0);
    send_item(tsm_pkg::LIST_B, 1'b0, 32'sd0, 1'b1);
    send_item(tsm_pkg::LIST_B, 1'b0, 32'sd0, 1'b1);
    send_item(tsm_pkg::LIST_B, 1'b1, 32'sd3, 1'b1);
    send_item(tsm_pkg::LIST_A, 1'b0, 32'sd0, 1'b1);
  endtask

  // Overfill one list while the other is open and empty, then finish both.
  task automatic test_queue_overflow();
    int   vals[$];
    logic side;
    bit   end_on_drop;
    repeat (3) begin
      side        = 1'($urandom_range(0, 1));
      end_on_drop = 1'($urandom_range(0, 1));
      vals        = {};
      repeat (DEPTH + $urandom_range(1, 3)) vals.push_back($urandom);
      vals.sort();
      foreach (vals[i]) send_item(side, 1'b1, vals[i], end_on_drop && i == vals.size() - 1);
      if (!end_on_drop) send_item(side, 1'b0, 32'sd0, 1'b1);
      repeat ($urandom_range(0, 3)) send_item(!side, 1'b1, $urandom, 1'b0);
      send_item(!side, 1'($urandom_range(0, 1)), $urandom, 1'b1);
    end
  endtask

  // Advance one list of a pair by one item; add noise now and then.
  task automatic send_step(logic which, ref int vals[$], ref int idx, input bit bare,
                           ref bit done, input bit other_done);
    bit closing;
    if (idx < vals.size()) begin
      closing = (idx == vals.size() - 1) && !bare;
      send_item(which, 1'b1, vals[idx], closing);
      idx++;
      done = closing;
    end else begin
      send_item(which, 1'b0, 32'sd0, 1'b1);
      done = 1'b1;
    end
    // Broken traffic: poke a list that has just ended while the other runs on.
    if (done && !other_done && $urandom_range(0, 9) == 0)
      send_item(which, 1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 19) == 0)
      send_item(1'($urandom_range(0, 1)), 1'b0, $urandom, 1'b0);
  endtask

  // Well-formed pairs with random content; a few unsorted lists as noise.
  task automatic test_random_merges();
    int   vals_a[$];
    int   vals_b[$];
    int   len_a;
    int   len_b;
    int   ia;
    int   ib;
    bit   narrow;
    bit   bare_a;
    bit   bare_b;
    bit   done_a;
    bit   done_b;
    logic pick;
    while (items_sent < ITEM_TARGET) begin
      len_a  = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6) : $urandom_range(7, 16);
      len_b  = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6) : $urandom_range(7, 16);
      narrow = ($urandom_range(0, 9) < 3);
      steady = ($urandom_range(0, 99) < 15);
      vals_a = {};
      vals_b = {};
      repeat (len_a) vals_a.push_back(narrow ? $urandom_range(0, 24) - 12 : $urandom);
      repeat (len_b) vals_b.push_back(narrow ? $urandom_range(0, 24) - 12 : $urandom);
      if ($urandom_range(0, 99) < 93) begin
        vals_a.sort();
        vals_b.sort();
      end
      bare_a = (len_a == 0) || ($urandom_range(0, 2) == 0);
      bare_b = (len_b == 0) || ($urandom_range(0, 2) == 0);
      ia     = 0;
      ib     = 0;
      done_a = 1'b0;
      done_b = 1'b0;
      while (!done_a || !done_b) begin
        if (done_a) pick = tsm_pkg::LIST_B;
        else if (done_b) pick = tsm_pkg::LIST_A;
        else pick = 1'($urandom_range(0, 1));
        if (pick == tsm_pkg::LIST_A) send_step(tsm_pkg::LIST_A, vals_a, ia, bare_a, done_a,
                                               done_b);
        else send_step(tsm_pkg::LIST_B, vals_b, ib, bare_b, done_b, done_a);
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
    steady = 1'b0;
  endtask

  initial begin : stimulus
    rst_n         = 1'b0;
    in_push       = 1'b0;
    in_which_list = tsm_pkg::LIST_A;
    in_has_value  = 1'b0;
    in_value      = '0;
    in_ends_list  = 1'b0;
    steady        = 1'b0;
    closed_a      = 1'b0;
    closed_b      = 1'b0;
    items_sent    = 0;
    results_seen  = 0;
    drop_count    = 0;
    merge_count   = 0;
    fault_count   = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_lists();
    test_extremes_and_ties();
    // Let the output side empty completely before the next phase.
    wait_drained();
    test_drop_after_end();
    test_queue_overflow();
    test_random_merges();

    // Drop the request, wait for the last transfer and let stragglers show.
    @(negedge clk);
    in_push = 1'b0;
    while (merged_expect.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Run covered %0d list items over %0d merges, %0d drops included.",
             items_sent, merge_count, drop_count);
    $display("Checked %0d results, %0d faults found.", results_seen, fault_count);
    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
